// ----- rtl/crt_pp_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pp_pkg
// Shared types and constants of the crt pixel post-processing pipeline.
// ----------------------------------------------------------------------------
package crt_pp_pkg;

  localparam int CHAN_W = 8;
  localparam int POS_W  = 12;
  localparam int INV_W  = 25;
  localparam int IDX_W  = 3;

  // product of position and reciprocal, and the normalized magnitude
  localparam int PROD_W = POS_W + INV_W;
  localparam int NORM_W = 18;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int DIST_W = 20;
  localparam int COEF_W = 15;
  localparam int SCL_W  = 19;
  localparam int GAIN_W = 17;

  localparam logic [NORM_W-1:0] NORM_SAT = 18'd131072;
  localparam logic [GAIN_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [COEF_W-1:0] VIG_COEF = 15'd29491;
  localparam logic [DIST_W-1:0] DIST_MAX = 20'd524288;

  // x/10 as (x*6554)>>16, exact for x below 2048
  localparam logic [12:0] DIV10_RECIP = 13'd6554;

  localparam logic [9:0] DITHER_OFS = 10'd12;

  localparam logic [1:0] BAYER [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

  typedef enum logic [IDX_W-1:0] {
    REG_SCANLINES = 3'd0,
    REG_DITHER    = 3'd1,
    REG_VIGNETTE  = 3'd2,
    REG_INV_W     = 3'd3,
    REG_INV_H     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic scanlines;
    logic dither;
    logic vignette;
  } cfg_t;

endpackage

// ----- rtl/crt_pp_front.sv -----
// ----------------------------------------------------------------------------
// crt_pp_front
// First stage: position clamp, scanline dimming and the position by
// reciprocal products that start the vignette coordinates.
// ----------------------------------------------------------------------------
module crt_pp_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                i_valid,
  output logic                                i_ready,
  input  crt_pp_pkg::pix_t                    i_pix,
  input  logic [crt_pp_pkg::POS_W-1:0]        i_x,
  input  logic [crt_pp_pkg::POS_W-1:0]        i_y,
  input  crt_pp_pkg::cfg_t                    cfg,
  input  logic [crt_pp_pkg::INV_W-1:0]        inv_w,
  input  logic [crt_pp_pkg::INV_W-1:0]        inv_h,
  output logic                                o_valid,
  input  logic                                o_ready,
  output crt_pp_pkg::pix_t                    o_pix,
  output logic                                o_x_lsb,
  output logic                                o_y_lsb,
  output logic [crt_pp_pkg::PROD_W-1:0]       o_px,
  output logic [crt_pp_pkg::PROD_W-1:0]       o_py
);

  localparam logic [crt_pp_pkg::POS_W-1:0] POS_LAST = crt_pp_pkg::POS_W'(MAX_DIM - 1);

  logic                           vld;
  logic                           en;
  logic [crt_pp_pkg::POS_W-1:0]   xc;
  logic [crt_pp_pkg::POS_W-1:0]   yc;
  logic                           dim;
  crt_pp_pkg::pix_t               pix_next;

  function automatic logic [crt_pp_pkg::CHAN_W-1:0] seven_tenths(
    input logic [crt_pp_pkg::CHAN_W-1:0] c
  );
    logic [10:0] c7;
    logic [23:0] p;
    begin
      c7 = ({3'b000, c} << 3) - {3'b000, c};
      p  = {13'd0, c7} * {11'd0, crt_pp_pkg::DIV10_RECIP};
      return p[23:16];
    end
  endfunction

  assign en      = !vld || o_ready;
  assign i_ready = en;
  assign o_valid = vld;

  always_comb begin
    xc = (32'(i_x) >= MAX_DIM) ? POS_LAST : i_x;
    yc = (32'(i_y) >= MAX_DIM) ? POS_LAST : i_y;
    dim = cfg.scanlines && !yc[0];
    pix_next = i_pix;
    if (dim) begin
      pix_next.red   = seven_tenths(i_pix.red);
      pix_next.green = seven_tenths(i_pix.green);
      pix_next.blue  = seven_tenths(i_pix.blue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && i_valid) begin
      o_pix   <= pix_next;
      o_x_lsb <= xc[0];
      o_y_lsb <= yc[0];
      o_px    <= {{crt_pp_pkg::INV_W{1'b0}}, xc} * {{crt_pp_pkg::POS_W{1'b0}}, inv_w};
      o_py    <= {{crt_pp_pkg::INV_W{1'b0}}, yc} * {{crt_pp_pkg::POS_W{1'b0}}, inv_h};
    end
  end

endmodule

// ----- rtl/crt_pp_norm.sv -----
// ----------------------------------------------------------------------------
// crt_pp_norm
// Second stage: ordered dither of the pixel and the absolute normalized
// coordinates, saturated at 2.0 in Q16.
// ----------------------------------------------------------------------------
module crt_pp_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                i_valid,
  output logic                                i_ready,
  input  crt_pp_pkg::pix_t                    i_pix,
  input  logic                                i_x_lsb,
  input  logic                                i_y_lsb,
  input  logic [crt_pp_pkg::PROD_W-1:0]       i_px,
  input  logic [crt_pp_pkg::PROD_W-1:0]       i_py,
  input  crt_pp_pkg::cfg_t                    cfg,
  output logic                                o_valid,
  input  logic                                o_ready,
  output crt_pp_pkg::pix_t                    o_pix,
  output logic [crt_pp_pkg::NORM_W-1:0]       o_ax,
  output logic [crt_pp_pkg::NORM_W-1:0]       o_ay
);

  localparam int T_W = crt_pp_pkg::PROD_W - 7;

  logic                                vld;
  logic                                en;
  logic [1:0]                          thr;
  crt_pp_pkg::pix_t                    pix_next;
  logic [crt_pp_pkg::NORM_W-1:0]       ax_next;
  logic [crt_pp_pkg::NORM_W-1:0]       ay_next;

  function automatic logic [crt_pp_pkg::CHAN_W-1:0] dither_chan(
    input logic [crt_pp_pkg::CHAN_W-1:0] c,
    input logic [1:0]                    t
  );
    logic signed [9:0] sum;
    logic [8:0]        q;
    begin
      sum = signed'({2'b00, c}) + signed'({5'b00000, t, 3'b000})
          - signed'(crt_pp_pkg::DITHER_OFS);
      q   = {sum[8:3], 3'b000};
      if (sum[9]) begin
        return '0;
      end else if (q > 9'd255) begin
        return 8'd255;
      end else begin
        return q[7:0];
      end
    end
  endfunction

  // |(2*pos*inv >> 8) - 1.0| in Q16, held at 2.0
  function automatic logic [crt_pp_pkg::NORM_W-1:0] norm_abs(
    input logic [crt_pp_pkg::PROD_W-1:0] p
  );
    logic [T_W-1:0] t;
    logic [T_W-1:0] a;
    begin
      t = p[crt_pp_pkg::PROD_W-1:7];
      a = (t >= T_W'(crt_pp_pkg::ONE_Q16)) ? t - T_W'(crt_pp_pkg::ONE_Q16)
                                            : T_W'(crt_pp_pkg::ONE_Q16) - t;
      if (a > T_W'(crt_pp_pkg::NORM_SAT)) begin
        return crt_pp_pkg::NORM_SAT;
      end else begin
        return a[crt_pp_pkg::NORM_W-1:0];
      end
    end
  endfunction

  assign en      = !vld || o_ready;
  assign i_ready = en;
  assign o_valid = vld;

  always_comb begin
    thr = crt_pp_pkg::BAYER[i_y_lsb][i_x_lsb];
    pix_next = i_pix;
    if (cfg.dither) begin
      pix_next.red   = dither_chan(i_pix.red, thr);
      pix_next.green = dither_chan(i_pix.green, thr);
      pix_next.blue  = dither_chan(i_pix.blue, thr);
    end
    ax_next = norm_abs(i_px);
    ay_next = norm_abs(i_py);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && i_valid) begin
      o_pix <= pix_next;
      o_ax  <= ax_next;
      o_ay  <= ay_next;
    end
  end

  a_norm_sat: assert property (@(posedge clk) disable iff (rst)
    vld |-> (o_ax <= crt_pp_pkg::NORM_SAT) && (o_ay <= crt_pp_pkg::NORM_SAT))
    else $error("normalized coordinate above saturation");

endmodule

// ----- rtl/crt_pp_vig.sv -----
// ----------------------------------------------------------------------------
// crt_pp_vig
// Last three stages: squared radius, vignette gain, and the gain applied
// to each channel into the output register.
// ----------------------------------------------------------------------------
module crt_pp_vig (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                i_valid,
  output logic                                i_ready,
  input  crt_pp_pkg::pix_t                    i_pix,
  input  logic [crt_pp_pkg::NORM_W-1:0]       i_ax,
  input  logic [crt_pp_pkg::NORM_W-1:0]       i_ay,
  input  crt_pp_pkg::cfg_t                    cfg,
  output logic                                o_valid,
  input  logic                                o_ready,
  output crt_pp_pkg::pix_t                    o_pix
);

  localparam int MUL_W = crt_pp_pkg::DIST_W + crt_pp_pkg::COEF_W;
  localparam int OUT_W = crt_pp_pkg::CHAN_W + crt_pp_pkg::GAIN_W;

  logic                                v3;
  logic                                v4;
  logic                                v5;
  logic                                en3;
  logic                                en4;
  logic                                en5;
  crt_pp_pkg::pix_t                    pix3;
  crt_pp_pkg::pix_t                    pix4;
  logic [crt_pp_pkg::DIST_W-1:0]       rad_sq;
  logic [crt_pp_pkg::GAIN_W-1:0]       gain;
  logic [crt_pp_pkg::SQ_W-1:0]         sq_sum;
  logic [MUL_W-1:0]                    scl_prod;
  logic [crt_pp_pkg::SCL_W-1:0]        scl;
  logic [crt_pp_pkg::GAIN_W-1:0]       gain_next;

  function automatic logic [crt_pp_pkg::CHAN_W-1:0] apply_gain(
    input logic [crt_pp_pkg::CHAN_W-1:0] c,
    input logic [crt_pp_pkg::GAIN_W-1:0] g
  );
    logic [OUT_W-1:0] p;
    begin
      p = {{crt_pp_pkg::GAIN_W{1'b0}}, c} * {{crt_pp_pkg::CHAN_W{1'b0}}, g};
      return p[16 +: crt_pp_pkg::CHAN_W];
    end
  endfunction

  assign en5     = !v5 || o_ready;
  assign en4     = !v4 || en5;
  assign en3     = !v3 || en4;
  assign i_ready = en3;
  assign o_valid = v5;

  always_comb begin
    sq_sum = {{crt_pp_pkg::NORM_W{1'b0}}, i_ax} * {{crt_pp_pkg::NORM_W{1'b0}}, i_ax}
           + {{crt_pp_pkg::NORM_W{1'b0}}, i_ay} * {{crt_pp_pkg::NORM_W{1'b0}}, i_ay};
    scl_prod = {{crt_pp_pkg::COEF_W{1'b0}}, rad_sq}
             * {{crt_pp_pkg::DIST_W{1'b0}}, crt_pp_pkg::VIG_COEF};
    scl = scl_prod[16 +: crt_pp_pkg::SCL_W];
    if (!cfg.vignette) begin
      gain_next = crt_pp_pkg::ONE_Q16;
    end else if (scl < crt_pp_pkg::SCL_W'(crt_pp_pkg::ONE_Q16)) begin
      gain_next = crt_pp_pkg::ONE_Q16 - scl[crt_pp_pkg::GAIN_W-1:0];
    end else begin
      gain_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en3) begin
        v3 <= i_valid;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && i_valid) begin
      pix3   <= i_pix;
      rad_sq <= sq_sum[16 +: crt_pp_pkg::DIST_W];
    end
    if (en4 && v3) begin
      pix4 <= pix3;
      gain <= gain_next;
    end
    if (en5 && v4) begin
      o_pix.red   <= apply_gain(pix4.red, gain);
      o_pix.green <= apply_gain(pix4.green, gain);
      o_pix.blue  <= apply_gain(pix4.blue, gain);
    end
  end

  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    v3 |-> rad_sq <= crt_pp_pkg::DIST_MAX)
    else $error("squared radius out of range");

  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    v4 |-> gain <= crt_pp_pkg::ONE_Q16)
    else $error("vignette gain above unity");

  a_gain_off: assert property (@(posedge clk) disable iff (rst)
    (en4 && v3 && !cfg.vignette) |=> gain == crt_pp_pkg::ONE_Q16)
    else $error("gain not unity with vignette off");

endmodule

// ----- rtl/crt_pixel_postprocess_core.sv -----
// ----------------------------------------------------------------------------
// crt_pixel_postprocess_core
// CRT-style pixel post-processing: scanline dimming, 2x2 ordered dither and
// radial vignette, applied in that order.
// ----------------------------------------------------------------------------
// One pixel enters per clock while in_stall is low; its word passes through the
// five register stages (clamp, scanline and coordinate products; dither and
// normalized coordinates; squared radius; vignette gain; gain multiply into
// the output register). Each stage holds its word while the next one cannot
// take it, so a stall on the output stops only the stages behind a full stage
// and empty slots close up. Configuration is written through the plain write
// port and takes effect for words accepted after the write; write only with
// the pipeline empty. No clearing pass is needed after reset.
module crt_pixel_postprocess_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [crt_pp_pkg::IDX_W-1:0]        wr_index,
  input  logic [crt_pp_pkg::INV_W-1:0]        wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [crt_pp_pkg::CHAN_W-1:0]       red_in,
  input  logic [crt_pp_pkg::CHAN_W-1:0]       green_in,
  input  logic [crt_pp_pkg::CHAN_W-1:0]       blue_in,
  input  logic [crt_pp_pkg::POS_W-1:0]        column,
  input  logic [crt_pp_pkg::POS_W-1:0]        row_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [crt_pp_pkg::CHAN_W-1:0]       red_out,
  output logic [crt_pp_pkg::CHAN_W-1:0]       green_out,
  output logic [crt_pp_pkg::CHAN_W-1:0]       blue_out
);

  crt_pp_pkg::cfg_t                    cfg;
  logic [crt_pp_pkg::INV_W-1:0]        inv_w;
  logic [crt_pp_pkg::INV_W-1:0]        inv_h;

  crt_pp_pkg::pix_t                    pix_in;
  crt_pp_pkg::pix_t                    pix1;
  crt_pp_pkg::pix_t                    pix2;
  crt_pp_pkg::pix_t                    pix_out;
  logic                                rdy1;
  logic                                rdy2;
  logic                                rdy3;
  logic                                v1;
  logic                                v2;
  logic                                x_lsb1;
  logic                                y_lsb1;
  logic [crt_pp_pkg::PROD_W-1:0]       px1;
  logic [crt_pp_pkg::PROD_W-1:0]       py1;
  logic [crt_pp_pkg::NORM_W-1:0]       ax2;
  logic [crt_pp_pkg::NORM_W-1:0]       ay2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg   <= '0;
      inv_w <= 25'd32768;
      inv_h <= 25'd32768;
    end else if (wr_en) begin
      case (crt_pp_pkg::reg_idx_t'(wr_index))
        crt_pp_pkg::REG_SCANLINES: begin
          cfg.scanlines <= wr_data[0];
        end
        crt_pp_pkg::REG_DITHER: begin
          cfg.dither <= wr_data[0];
        end
        crt_pp_pkg::REG_VIGNETTE: begin
          cfg.vignette <= wr_data[0];
        end
        crt_pp_pkg::REG_INV_W: begin
          inv_w <= wr_data;
        end
        crt_pp_pkg::REG_INV_H: begin
          inv_h <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign pix_in.red   = red_in;
  assign pix_in.green = green_in;
  assign pix_in.blue  = blue_in;
  assign in_stall     = !rdy1;

  crt_pp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .i_valid (in_valid),
    .i_ready (rdy1),
    .i_pix   (pix_in),
    .i_x     (column),
    .i_y     (row_index),
    .cfg     (cfg),
    .inv_w   (inv_w),
    .inv_h   (inv_h),
    .o_valid (v1),
    .o_ready (rdy2),
    .o_pix   (pix1),
    .o_x_lsb (x_lsb1),
    .o_y_lsb (y_lsb1),
    .o_px    (px1),
    .o_py    (py1)
  );

  crt_pp_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .i_valid (v1),
    .i_ready (rdy2),
    .i_pix   (pix1),
    .i_x_lsb (x_lsb1),
    .i_y_lsb (y_lsb1),
    .i_px    (px1),
    .i_py    (py1),
    .cfg     (cfg),
    .o_valid (v2),
    .o_ready (rdy3),
    .o_pix   (pix2),
    .o_ax    (ax2),
    .o_ay    (ay2)
  );

  crt_pp_vig u_vig (
    .clk     (clk),
    .rst     (rst),
    .i_valid (v2),
    .i_ready (rdy3),
    .i_pix   (pix2),
    .i_ax    (ax2),
    .i_ay    (ay2),
    .cfg     (cfg),
    .o_valid (out_valid),
    .o_ready (!out_stall),
    .o_pix   (pix_out)
  );

  assign red_out   = pix_out.red;
  assign green_out = pix_out.green;
  assign blue_out  = pix_out.blue;

endmodule
